// ----- rtl/rvid_pkg.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// rvid_pkg
// Shared types and encodings for the RV32I instruction decoder pipeline.
// ----------------------------------------------------------------------------
package rvid_pkg;

  localparam int unsigned WordW = 32;
  localparam int unsigned IdW   = 6;
  localparam int unsigned RegW  = 5;
  localparam int unsigned OutW  = 56;  // id, rd, rs1, rs2, imm, zero pad to bytes

  typedef logic [WordW-1:0] word_t;
  typedef logic [IdW-1:0]   id_t;
  typedef logic [2:0]       fmt_t;

  // instruction formats
  localparam fmt_t FMT_R = 3'd0;
  localparam fmt_t FMT_I = 3'd1;
  localparam fmt_t FMT_S = 3'd2;
  localparam fmt_t FMT_B = 3'd3;
  localparam fmt_t FMT_U = 3'd4;
  localparam fmt_t FMT_J = 3'd5;

  // major opcodes
  localparam logic [6:0] OP_LUI    = 7'h37;
  localparam logic [6:0] OP_AUIPC  = 7'h17;
  localparam logic [6:0] OP_JAL    = 7'h6F;
  localparam logic [6:0] OP_JALR   = 7'h67;
  localparam logic [6:0] OP_BRANCH = 7'h63;
  localparam logic [6:0] OP_LOAD   = 7'h03;
  localparam logic [6:0] OP_STORE  = 7'h23;
  localparam logic [6:0] OP_IMM    = 7'h13;
  localparam logic [6:0] OP_REG    = 7'h33;
  localparam logic [6:0] OP_SYSTEM = 7'h73;

  localparam logic [6:0] F7_ZERO = 7'h00;
  localparam logic [6:0] F7_ALT  = 7'h20;

  // instruction numbers in listing order
  localparam id_t ID_LUI    = 6'd0;
  localparam id_t ID_AUIPC  = 6'd1;
  localparam id_t ID_JAL    = 6'd2;
  localparam id_t ID_JALR   = 6'd3;
  localparam id_t ID_BEQ    = 6'd4;
  localparam id_t ID_BNE    = 6'd5;
  localparam id_t ID_BLT    = 6'd6;
  localparam id_t ID_BGE    = 6'd7;
  localparam id_t ID_BLTU   = 6'd8;
  localparam id_t ID_BGEU   = 6'd9;
  localparam id_t ID_LB     = 6'd10;
  localparam id_t ID_LH     = 6'd11;
  localparam id_t ID_LW     = 6'd12;
  localparam id_t ID_LBU    = 6'd13;
  localparam id_t ID_LHU    = 6'd14;
  localparam id_t ID_SB     = 6'd15;
  localparam id_t ID_SH     = 6'd16;
  localparam id_t ID_SW     = 6'd17;
  localparam id_t ID_ADDI   = 6'd18;
  localparam id_t ID_SLTI   = 6'd19;
  localparam id_t ID_SLTIU  = 6'd20;
  localparam id_t ID_XORI   = 6'd21;
  localparam id_t ID_ORI    = 6'd22;
  localparam id_t ID_ANDI   = 6'd23;
  localparam id_t ID_SLLI   = 6'd24;
  localparam id_t ID_SRLI   = 6'd25;
  localparam id_t ID_SRAI   = 6'd26;
  localparam id_t ID_ADD    = 6'd27;
  localparam id_t ID_SUB    = 6'd28;
  localparam id_t ID_SLL    = 6'd29;
  localparam id_t ID_SLT    = 6'd30;
  localparam id_t ID_SLTU   = 6'd31;
  localparam id_t ID_XOR    = 6'd32;
  localparam id_t ID_SRL    = 6'd33;
  localparam id_t ID_SRA    = 6'd34;
  localparam id_t ID_OR     = 6'd35;
  localparam id_t ID_AND    = 6'd36;
  localparam id_t ID_ECALL  = 6'd37;
  localparam id_t ID_EBREAK = 6'd38;

  // classification handed from the decode stage to the output stage
  typedef struct packed {
    logic ok;
    id_t  id;
    fmt_t fmt;
  } cls_t;

endpackage
`default_nettype wire

// ----- rtl/rv32i_instruction_decoder_top.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// rv32i_instruction_decoder_top
// Pipelined RV32I decoder: instruction number, register indices, immediate.
// ----------------------------------------------------------------------------
//  channel | dir | ports                        | content
//  in_     | in  | tvalid tready tdata[31:0]    | instruction word
//  out_    | out | tvalid tready tdata[55:0]    | id, rd, rs1, rs2, immediate
//          |     | tuser[0]                     | recognized flag
//
//  One request per cycle while out_tready does not stall; three register
//  stages (capture, classify, field assembly) lie between in_ and out_.
//  A stall at out_tready freezes all stages together; in_tready follows it.
//  Reset clears the stage valid bits only.
// ----------------------------------------------------------------------------
module rv32i_instruction_decoder_top (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [31:0] in_tdata,   // [31:0] instr_word
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [55:0]      out_tdata,  // [5:0] instr_id, [10:6] dest_reg,
                                       // [15:11] src1_reg, [20:16] src2_reg,
                                       // [52:21] immediate, [55:53] zero
  output logic [0:0]       out_tuser   // [0] valid_res
);
  import rvid_pkg::*;

  logic  adv;
  logic  a_vld_r;
  word_t a_word_r;
  logic  b_vld_r;
  word_t b_word_r;
  cls_t  b_cls_r;
  logic  c_vld_r;
  logic [OutW-1:0] c_data_r;
  logic  c_ok_r;

  logic [OutW-1:0] c_data_nxt;
  word_t imm;
  logic [RegW-1:0] rd, rs1, rs2;

  // advance every stage whenever the output slot is free or being drained
  assign adv       = !c_vld_r || out_tready;
  assign in_tready = adv;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_vld_r <= 1'b0;
    end else if (adv) begin
      a_vld_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      a_word_r <= in_tdata;
    end
  end

  rvid_classify u_cls (
    .clk    (clk),
    .rst_n  (rst_n),
    .en     (adv),
    .vld_i  (a_vld_r),
    .word_i (a_word_r),
    .vld_r  (b_vld_r),
    .word_r (b_word_r),
    .cls_r  (b_cls_r)
  );

  always_comb begin
    rd  = b_word_r[11:7];
    rs1 = b_word_r[19:15];
    rs2 = b_word_r[24:20];
    imm = '0;
    unique case (b_cls_r.fmt)
      FMT_I: begin
        rs2 = '0;
        imm = {{21{b_word_r[31]}}, b_word_r[30:20]};
      end
      FMT_S: begin
        rd  = '0;
        imm = {{21{b_word_r[31]}}, b_word_r[30:25], b_word_r[11:7]};
      end
      FMT_B: begin
        rd  = '0;
        imm = {{20{b_word_r[31]}}, b_word_r[7], b_word_r[30:25],
               b_word_r[11:8], 1'b0};
      end
      FMT_U: begin
        rs1 = '0;
        rs2 = '0;
        imm = {b_word_r[31:12], 12'd0};
      end
      FMT_J: begin
        rs1 = '0;
        rs2 = '0;
        imm = {{12{b_word_r[31]}}, b_word_r[19:12], b_word_r[20],
               b_word_r[30:21], 1'b0};
      end
      default: ;
    endcase
    // drop every field of an unrecognized word
    c_data_nxt = b_cls_r.ok ? {3'd0, imm, rs2, rs1, rd, b_cls_r.id} : '0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      c_vld_r <= 1'b0;
    end else if (adv) begin
      c_vld_r <= b_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      c_data_r <= c_data_nxt;
      c_ok_r   <= b_cls_r.ok;
    end
  end

  assign out_tvalid   = c_vld_r;
  assign out_tdata    = c_data_r;
  assign out_tuser[0] = c_ok_r;

`ifndef SYNTH
  a_unknown_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && !out_tuser[0]) |-> (out_tdata == '0))
    else $error("unrecognized word carries nonzero fields");

  a_id_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (out_tdata[5:0] <= ID_EBREAK))
    else $error("instruction number out of range");

  a_branch_no_rd: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tuser[0] && out_tdata[5:0] >= ID_BEQ
     && out_tdata[5:0] <= ID_BGEU) |-> (out_tdata[10:6] == '0))
    else $error("branch result carries a destination register");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && !out_tready) |=>
      (out_tvalid && $stable(out_tdata) && $stable(out_tuser)))
    else $error("stalled result changed before it was taken");
`endif

endmodule
`default_nettype wire

// ----- rtl/rvid_classify.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// rvid_classify
// Decode stage: opcode/funct3/funct7 classification of one word, registered.
// ----------------------------------------------------------------------------
module rvid_classify (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          en,
  input  wire logic          vld_i,
  input  wire rvid_pkg::word_t word_i,
  output logic               vld_r,
  output rvid_pkg::word_t    word_r,
  output rvid_pkg::cls_t     cls_r
);
  import rvid_pkg::*;

  logic [6:0] op;
  logic [2:0] f3;
  logic [6:0] f7;
  cls_t       cls_nxt;

  assign op = word_i[6:0];
  assign f3 = word_i[14:12];
  assign f7 = word_i[31:25];

  always_comb begin
    cls_nxt = '{ok: 1'b1, id: ID_LUI, fmt: FMT_R};
    unique case (op)
      OP_LUI:   begin cls_nxt.fmt = FMT_U; cls_nxt.id = ID_LUI;   end
      OP_AUIPC: begin cls_nxt.fmt = FMT_U; cls_nxt.id = ID_AUIPC; end
      OP_JAL:   begin cls_nxt.fmt = FMT_J; cls_nxt.id = ID_JAL;   end
      OP_JALR: begin
        cls_nxt.fmt = FMT_I;
        cls_nxt.id  = ID_JALR;
        cls_nxt.ok  = (f3 == 3'd0);
      end
      OP_BRANCH: begin
        cls_nxt.fmt = FMT_B;
        unique case (f3)
          3'd0:    cls_nxt.id = ID_BEQ;
          3'd1:    cls_nxt.id = ID_BNE;
          3'd4:    cls_nxt.id = ID_BLT;
          3'd5:    cls_nxt.id = ID_BGE;
          3'd6:    cls_nxt.id = ID_BLTU;
          3'd7:    cls_nxt.id = ID_BGEU;
          default: cls_nxt.ok = 1'b0;
        endcase
      end
      OP_LOAD: begin
        cls_nxt.fmt = FMT_I;
        unique case (f3)
          3'd0:    cls_nxt.id = ID_LB;
          3'd1:    cls_nxt.id = ID_LH;
          3'd2:    cls_nxt.id = ID_LW;
          3'd4:    cls_nxt.id = ID_LBU;
          3'd5:    cls_nxt.id = ID_LHU;
          default: cls_nxt.ok = 1'b0;
        endcase
      end
      OP_STORE: begin
        cls_nxt.fmt = FMT_S;
        unique case (f3)
          3'd0:    cls_nxt.id = ID_SB;
          3'd1:    cls_nxt.id = ID_SH;
          3'd2:    cls_nxt.id = ID_SW;
          default: cls_nxt.ok = 1'b0;
        endcase
      end
      OP_IMM: begin
        cls_nxt.fmt = FMT_I;
        unique case (f3)
          3'd0: cls_nxt.id = ID_ADDI;
          3'd2: cls_nxt.id = ID_SLTI;
          3'd3: cls_nxt.id = ID_SLTIU;
          3'd4: cls_nxt.id = ID_XORI;
          3'd6: cls_nxt.id = ID_ORI;
          3'd7: cls_nxt.id = ID_ANDI;
          3'd1: begin
            cls_nxt.id = ID_SLLI;
            cls_nxt.ok = (f7 == F7_ZERO);
          end
          default: begin
            cls_nxt.id = (f7 == F7_ALT) ? ID_SRAI : ID_SRLI;
            cls_nxt.ok = (f7 == F7_ZERO) || (f7 == F7_ALT);
          end
        endcase
      end
      OP_REG: begin
        cls_nxt.fmt = FMT_R;
        if (f7 == F7_ZERO) begin
          unique case (f3)
            3'd0:    cls_nxt.id = ID_ADD;
            3'd1:    cls_nxt.id = ID_SLL;
            3'd2:    cls_nxt.id = ID_SLT;
            3'd3:    cls_nxt.id = ID_SLTU;
            3'd4:    cls_nxt.id = ID_XOR;
            3'd5:    cls_nxt.id = ID_SRL;
            3'd6:    cls_nxt.id = ID_OR;
            default: cls_nxt.id = ID_AND;
          endcase
        end else if (f7 == F7_ALT && f3 == 3'd0) begin
          cls_nxt.id = ID_SUB;
        end else if (f7 == F7_ALT && f3 == 3'd5) begin
          cls_nxt.id = ID_SRA;
        end else begin
          cls_nxt.ok = 1'b0;
        end
      end
      OP_SYSTEM: begin
        cls_nxt.fmt = FMT_I;
        cls_nxt.id  = word_i[20] ? ID_EBREAK : ID_ECALL;
        // rd, rs1, funct3 zero and imm 0 or 1
        cls_nxt.ok  = (word_i[19:7] == 13'd0) && (word_i[31:21] == 11'd0);
      end
      default: cls_nxt.ok = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (en) begin
      vld_r <= vld_i;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      word_r <= word_i;
      cls_r  <= cls_nxt;
    end
  end

endmodule
`default_nettype wire

// ----- tb/rv32i_instruction_decoder_top_tb.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// rv32i_instruction_decoder_top_tb
// Streams RV32I instruction words through the decoder and checks each decode.
// A queue of words feeds a clocked driver; a clocked monitor compares every
// result with the next expected decode. The expected decode comes from a
// decoder function inside this bench. The run starts with hand-picked edge
// encodings, then mostly well-formed random words with some noise mixed in.
// Both handshakes idle at random, and the receiver holds off once for a long
// stretch.
// ----------------------------------------------------------------------------
module rv32i_instruction_decoder_top_tb;
  import rvid_pkg::*;

  localparam int CYCLE_LIMIT  = 200000;
  localparam int RANDOM_WORDS = 650;
  localparam int HOLD_CYCLES  = 90;
  localparam int HOLD_AT      = 520;

  // funct3 encodings
  localparam logic [2:0] F3_BEQ  = 3'd0, F3_BNE = 3'd1, F3_BLT = 3'd4, F3_BGE = 3'd5;
  localparam logic [2:0] F3_BLTU = 3'd6, F3_BGEU = 3'd7;
  localparam logic [2:0] F3_B    = 3'd0, F3_H = 3'd1, F3_W = 3'd2, F3_BU = 3'd4;
  localparam logic [2:0] F3_HU   = 3'd5;
  localparam logic [2:0] F3_ADD  = 3'd0, F3_SLL = 3'd1, F3_SLT = 3'd2, F3_SLTU = 3'd3;
  localparam logic [2:0] F3_XOR  = 3'd4, F3_SR = 3'd5, F3_OR = 3'd6, F3_AND = 3'd7;
  localparam logic [2:0] F3_JALR = 3'd0, F3_PRIV = 3'd0;
  localparam logic [11:0] IMM_ECALL = 12'd0, IMM_EBREAK = 12'd1;
  localparam logic [6:0] OP_FENCE = 7'h0F;

  typedef struct packed {
    logic      ok;
    id_t       id;
    logic [4:0] rd;
    logic [4:0] rs1;
    logic [4:0] rs2;
    word_t     imm;
  } decoded_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [31:0] in_tdata = '0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [55:0] out_tdata;
  logic [0:0]  out_tuser;

  word_t    fetch_words[$];
  decoded_t pending_decodes[$];
  decoded_t got_decode, want_decode;
  logic     id_seen[64];

  int words_taken = 0;
  int decodes_checked = 0;
  int recognized = 0;
  int mismatches = 0;
  int cycle_cnt = 0;
  int hold_left = 0;
  logic hold_done = 1'b0;
  int send_gap_pct, recv_stall_pct;

  rv32i_instruction_decoder_top u_top (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

  always #10 clk = ~clk;

  function automatic word_t pack_instr(logic [6:0] op, logic [2:0] f3, logic [6:0] f7,
                                       logic [4:0] rd, logic [4:0] rs1, logic [4:0] rs2);
    return {f7, rs2, rs1, f3, rd, op};
  endfunction

  function automatic decoded_t decode_word(word_t w);
    decoded_t   d;
    fmt_t       fmt;
    logic [6:0] op;
    logic [6:0] f7;
    logic [2:0] f3;
    op = w[6:0];
    f3 = w[14:12];
    f7 = w[31:25];
    d = '0;
    d.ok = 1'b1;
    fmt = FMT_R;
    case (op)
      OP_LUI: begin
        fmt = FMT_U;
        d.id = ID_LUI;
      end
      OP_AUIPC: begin
        fmt = FMT_U;
        d.id = ID_AUIPC;
      end
      OP_JAL: begin
        fmt = FMT_J;
        d.id = ID_JAL;
      end
      OP_JALR: begin
        fmt = FMT_I;
        d.id = ID_JALR;
        d.ok = (f3 == F3_JALR);
      end
      OP_BRANCH: begin
        fmt = FMT_B;
        case (f3)
          F3_BEQ:  d.id = ID_BEQ;
          F3_BNE:  d.id = ID_BNE;
          F3_BLT:  d.id = ID_BLT;
          F3_BGE:  d.id = ID_BGE;
          F3_BLTU: d.id = ID_BLTU;
          F3_BGEU: d.id = ID_BGEU;
          default: d.ok = 1'b0;
        endcase
      end
      OP_LOAD: begin
        fmt = FMT_I;
        case (f3)
          F3_B:    d.id = ID_LB;
          F3_H:    d.id = ID_LH;
          F3_W:    d.id = ID_LW;
          F3_BU:   d.id = ID_LBU;
          F3_HU:   d.id = ID_LHU;
          default: d.ok = 1'b0;
        endcase
      end
      OP_STORE: begin
        fmt = FMT_S;
        case (f3)
          F3_B:    d.id = ID_SB;
          F3_H:    d.id = ID_SH;
          F3_W:    d.id = ID_SW;
          default: d.ok = 1'b0;
        endcase
      end
      OP_IMM: begin
        fmt = FMT_I;
        case (f3)
          F3_ADD:  d.id = ID_ADDI;
          F3_SLT:  d.id = ID_SLTI;
          F3_SLTU: d.id = ID_SLTIU;
          F3_XOR:  d.id = ID_XORI;
          F3_OR:   d.id = ID_ORI;
          F3_AND:  d.id = ID_ANDI;
          F3_SLL: begin
            d.id = ID_SLLI;
            d.ok = (f7 == F7_ZERO);
          end
          default: begin
            d.id = (f7 == F7_ALT) ? ID_SRAI : ID_SRLI;
            d.ok = (f7 == F7_ZERO) || (f7 == F7_ALT);
          end
        endcase
      end
      OP_REG: begin
        if (f7 == F7_ZERO) begin
          case (f3)
            F3_ADD:  d.id = ID_ADD;
            F3_SLL:  d.id = ID_SLL;
            F3_SLT:  d.id = ID_SLT;
            F3_SLTU: d.id = ID_SLTU;
            F3_XOR:  d.id = ID_XOR;
            F3_SR:   d.id = ID_SRL;
            F3_OR:   d.id = ID_OR;
            default: d.id = ID_AND;
          endcase
        end else if (f7 == F7_ALT && f3 == F3_ADD) begin
          d.id = ID_SUB;
        end else if (f7 == F7_ALT && f3 == F3_SR) begin
          d.id = ID_SRA;
        end else begin
          d.ok = 1'b0;
        end
      end
      OP_SYSTEM: begin
        fmt = FMT_I;
        if (f3 != F3_PRIV || w[11:7] != 5'd0 || w[19:15] != 5'd0) begin
          d.ok = 1'b0;
        end else if (w[31:20] == IMM_ECALL) begin
          d.id = ID_ECALL;
        end else if (w[31:20] == IMM_EBREAK) begin
          d.id = ID_EBREAK;
        end else begin
          d.ok = 1'b0;
        end
      end
      default: d.ok = 1'b0;
    endcase
    if (!d.ok) return '0;

    d.rd  = w[11:7];
    d.rs1 = w[19:15];
    d.rs2 = w[24:20];
    case (fmt)
      FMT_I: begin
        d.rs2 = '0;
        d.imm = {{21{w[31]}}, w[30:20]};
      end
      FMT_S: begin
        d.rd  = '0;
        d.imm = {{21{w[31]}}, w[30:25], w[11:7]};
      end
      FMT_B: begin
        d.rd  = '0;
        d.imm = {{20{w[31]}}, w[7], w[30:25], w[11:8], 1'b0};
      end
      FMT_U: begin
        d.rs1 = '0;
        d.rs2 = '0;
        d.imm = {w[31:12], 12'd0};
      end
      FMT_J: begin
        d.rs1 = '0;
        d.rs2 = '0;
        d.imm = {{12{w[31]}}, w[19:12], w[20], w[30:21], 1'b0};
      end
      default: ;
    endcase
    return d;
  endfunction

  // sender gaps at a 23 percent chance and receiver stalls at 85 percent, then
  // swapped, then no random idling at all
  assign send_gap_pct   = (words_taken < 230) ? 23 : (words_taken < 460) ? 85 : 0;
  assign recv_stall_pct = (words_taken < 230) ? 85 : (words_taken < 460) ? 23 : 0;

  // driver: record the prediction for a taken request, then load the next word
  always @(posedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
      in_tdata  <= '0;
    end else begin
      if (in_tvalid && in_tready) begin
        pending_decodes.push_back(decode_word(in_tdata));
        words_taken <= words_taken + 1;
      end
      if (!in_tvalid || in_tready) begin
        if (fetch_words.size() != 0 && $urandom_range(99) >= send_gap_pct) begin
          in_tvalid <= 1'b1;
          in_tdata  <= fetch_words.pop_front();
        end else begin
          in_tvalid <= 1'b0;
        end
      end
    end
  end

  // one long receiver hold-off while the sender keeps offering
  always @(posedge clk) begin
    if (!rst_n) begin
      hold_left <= 0;
      hold_done <= 1'b0;
    end else if (!hold_done && words_taken >= HOLD_AT) begin
      hold_left <= HOLD_CYCLES;
      hold_done <= 1'b1;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
    end
  end

  always @(posedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else begin
      if (out_tvalid && out_tready) begin
        got_decode.ok  = out_tuser[0];
        got_decode.id  = out_tdata[5:0];
        got_decode.rd  = out_tdata[10:6];
        got_decode.rs1 = out_tdata[15:11];
        got_decode.rs2 = out_tdata[20:16];
        got_decode.imm = out_tdata[52:21];
        decodes_checked++;
        if (got_decode.ok) begin
          recognized++;
          id_seen[got_decode.id] = 1'b1;
        end
        if (pending_decodes.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("[%0t] unexpected result: valid=%0d id=%0d rd=%0d rs1=%0d rs2=%0d imm=%h",
                     $realtime, got_decode.ok, got_decode.id, got_decode.rd,
                     got_decode.rs1, got_decode.rs2, got_decode.imm);
        end else begin
          want_decode = pending_decodes.pop_front();
          if (got_decode !== want_decode) begin
            mismatches++;
            if (mismatches <= 10) begin
              $display("[%0t] mismatch on result %0d", $realtime, decodes_checked);
              $display("  expected valid=%0d id=%0d rd=%0d rs1=%0d rs2=%0d imm=%h",
                       want_decode.ok, want_decode.id, want_decode.rd,
                       want_decode.rs1, want_decode.rs2, want_decode.imm);
              $display("  actual   valid=%0d id=%0d rd=%0d rs1=%0d rs2=%0d imm=%h",
                       got_decode.ok, got_decode.id, got_decode.rd,
                       got_decode.rs1, got_decode.rs2, got_decode.imm);
            end
          end
        end
      end
      out_tready <= (hold_left == 0) && ($urandom_range(99) >= recv_stall_pct);
    end
  end

  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt == CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results outstanding",
               cycle_cnt, pending_decodes.size());
      $display("CHECKS FAILED");
      $finish;
    end
  end

  initial begin
    int    i;
    int    kinds;
    word_t w;

    foreach (id_seen[k]) id_seen[k] = 1'b0;

    // edge encodings and the corner cases of the format rules
    fetch_words.push_back(32'h0000_0000);
    fetch_words.push_back(32'hFFFF_FFFF);
    fetch_words.push_back(pack_instr(OP_LUI, 3'h7, 7'h7F, 5'd31, 5'd31, 5'd31));
    fetch_words.push_back(pack_instr(OP_AUIPC, 3'h0, 7'h00, 5'd0, 5'd0, 5'd0));
    fetch_words.push_back(pack_instr(OP_JAL, 3'h7, 7'h7F, 5'd31, 5'd31, 5'd31));
    fetch_words.push_back(pack_instr(OP_JAL, 3'h7, 7'h3F, 5'd1, 5'd31, 5'd31));
    fetch_words.push_back(pack_instr(OP_JALR, F3_JALR, 7'h7F, 5'd31, 5'd31, 5'd31));
    fetch_words.push_back(pack_instr(OP_JALR, 3'h3, 7'h00, 5'd1, 5'd2, 5'd3));
    fetch_words.push_back(pack_instr(OP_BRANCH, F3_BEQ, 7'h7F, 5'd31, 5'd31, 5'd31));
    fetch_words.push_back(pack_instr(OP_BRANCH, F3_BGEU, 7'h3F, 5'd30, 5'd2, 5'd3));
    fetch_words.push_back(pack_instr(OP_BRANCH, 3'h2, 7'h00, 5'd1, 5'd2, 5'd3));
    fetch_words.push_back(pack_instr(OP_LOAD, 3'h3, 7'h00, 5'd1, 5'd2, 5'd3));
    fetch_words.push_back(pack_instr(OP_LOAD, F3_HU, 7'h7F, 5'd31, 5'd31, 5'd31));
    fetch_words.push_back(pack_instr(OP_STORE, F3_W, 7'h7F, 5'd31, 5'd31, 5'd31));
    fetch_words.push_back(pack_instr(OP_STORE, 3'h4, 7'h00, 5'd1, 5'd2, 5'd3));
    fetch_words.push_back(pack_instr(OP_IMM, F3_SLL, F7_ZERO, 5'd5, 5'd6, 5'd31));
    fetch_words.push_back(pack_instr(OP_IMM, F3_SLL, F7_ALT, 5'd5, 5'd6, 5'd7));
    fetch_words.push_back(pack_instr(OP_IMM, F3_SR, F7_ALT, 5'd5, 5'd6, 5'd31));
    fetch_words.push_back(pack_instr(OP_IMM, F3_SR, F7_ZERO, 5'd5, 5'd6, 5'd1));
    fetch_words.push_back(pack_instr(OP_IMM, F3_SR, 7'h01, 5'd5, 5'd6, 5'd1));
    fetch_words.push_back(pack_instr(OP_REG, F3_SR, F7_ZERO, 5'd31, 5'd31, 5'd31));
    fetch_words.push_back(pack_instr(OP_REG, F3_SR, F7_ALT, 5'd1, 5'd2, 5'd3));
    fetch_words.push_back(pack_instr(OP_REG, F3_ADD, F7_ALT, 5'd1, 5'd2, 5'd3));
    fetch_words.push_back(pack_instr(OP_REG, F3_SLL, F7_ALT, 5'd1, 5'd2, 5'd3));
    fetch_words.push_back({IMM_ECALL, 5'd0, F3_PRIV, 5'd0, OP_SYSTEM});
    fetch_words.push_back({IMM_EBREAK, 5'd0, F3_PRIV, 5'd0, OP_SYSTEM});
    fetch_words.push_back({12'd2, 5'd0, F3_PRIV, 5'd0, OP_SYSTEM});
    fetch_words.push_back({IMM_ECALL, 5'd0, F3_PRIV, 5'd1, OP_SYSTEM});
    fetch_words.push_back({12'd0, 5'd0, 3'd0, 5'd0, OP_FENCE});

    // mostly real opcodes with random fields, the rest raw noise
    for (i = 0; i < RANDOM_WORDS; i++) begin
      w = $urandom;
      if ($urandom_range(99) < 75) begin
        case ($urandom_range(9))
          0: w[6:0] = OP_LUI;
          1: w[6:0] = OP_AUIPC;
          2: w[6:0] = OP_JAL;
          3: begin
            w[6:0] = OP_JALR;
            if ($urandom_range(4) != 0) w[14:12] = F3_JALR;
          end
          4: w[6:0] = OP_BRANCH;
          5: w[6:0] = OP_LOAD;
          6: w[6:0] = OP_STORE;
          7: begin
            w[6:0] = OP_IMM;
            if ($urandom_range(4) != 0) w[31:25] = $urandom_range(1) ? F7_ALT : F7_ZERO;
          end
          8: begin
            w[6:0] = OP_REG;
            if ($urandom_range(9) != 0) w[31:25] = $urandom_range(1) ? F7_ALT : F7_ZERO;
          end
          default: begin
            w[6:0] = OP_SYSTEM;
            if ($urandom_range(3) != 0) begin
              w[11:7]  = 5'd0;
              w[14:12] = F3_PRIV;
              w[19:15] = 5'd0;
              w[31:20] = $urandom_range(1) ? IMM_EBREAK : IMM_ECALL;
            end
          end
        endcase
      end
      fetch_words.push_back(w);
    end

    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    // drain: every word taken and every decode returned
    while (fetch_words.size() != 0 || in_tvalid || pending_decodes.size() != 0)
      @(negedge clk);
    repeat (10) @(posedge clk);

    kinds = 0;
    foreach (id_seen[k]) if (id_seen[k]) kinds++;
    $display("decoded %0d words (%0d recognized), %0d of 39 instruction kinds seen",
             decodes_checked, recognized, kinds);
    $display("gaps and stalls on both sides plus one %0d-cycle hold-off, %0d mismatches",
             HOLD_CYCLES, mismatches);
    if (mismatches == 0 && pending_decodes.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

// ----- rv32i_instruction_decoder_top.f -----
rtl/rvid_pkg.sv
rtl/rvid_classify.sv
rtl/rv32i_instruction_decoder_top.sv
tb/rv32i_instruction_decoder_top_tb.sv
